FILE: src/tfm_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the target follow mode controller.
package tfm_pkg;

	localparam int unsigned VisualTimeoutMs = 500;

	// follow mode, one-hot state encoding
	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_LOCK   = 6'b000010,
		MODE_FUSED  = 6'b000100,
		MODE_HOLD   = 6'b001000,
		MODE_SEARCH = 6'b010000,
		MODE_STOP   = 6'b100000
	} mode_t;

	// mode as reported on the result word
	localparam logic [2:0] MODE_CODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_CODE_LOCK   = 3'd1;
	localparam logic [2:0] MODE_CODE_FUSED  = 3'd2;
	localparam logic [2:0] MODE_CODE_HOLD   = 3'd3;
	localparam logic [2:0] MODE_CODE_SEARCH = 3'd4;
	localparam logic [2:0] MODE_CODE_STOP   = 3'd5;

	typedef enum logic [2:0] {
		CAUSE_NONE     = 3'd0,
		CAUSE_CAMERA   = 3'd1,
		CAUSE_SCAN     = 3'd2,
		CAUSE_CLOSE    = 3'd3,
		CAUSE_JUMP     = 3'd4,
		CAUSE_VIS_LOST = 3'd5
	} cause_t;

	// configuration register indexes
	localparam logic [2:0] REG_DESIRED_DIST = 3'd0;
	localparam logic [2:0] REG_MIN_SAFE     = 3'd1;
	localparam logic [2:0] REG_LIN_GAIN     = 3'd2;
	localparam logic [2:0] REG_ANG_GAIN     = 3'd3;
	localparam logic [2:0] REG_LIN_LIMIT    = 3'd4;
	localparam logic [2:0] REG_ANG_LIMIT    = 3'd5;
	localparam logic [2:0] REG_HOLD_TIMEOUT = 3'd6;
	localparam logic [2:0] REG_MAX_JUMP     = 3'd7;

	typedef struct packed {
		logic [15:0] desired_distance_mm;
		logic [15:0] min_safe_distance_mm;
		logic [15:0] linear_gain;
		logic [15:0] angular_gain;
		logic [14:0] linear_limit;
		logic [14:0] angular_limit;
		logic [15:0] hold_timeout_ms;
		logic [12:0] max_jump_mrad;
	} cfg_t;

	typedef struct packed {
		logic               target_seen;
		logic               cam_calib_ok;
		logic               scan_stale;
		logic               lidar_match;
		logic [9:0]         lidar_points;
		logic [15:0]        lidar_distance_mm;
		logic signed [12:0] bearing_mrad;
		logic [31:0]        visual_time_ms;
		logic [31:0]        now_ms;
	} item_t;

	// command request from the mode logic to the scale/clamp units
	typedef struct packed {
		logic               en;
		logic signed [16:0] lin_err;
		logic signed [16:0] ang_err;
	} drive_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [15:0] linear_cmd;
		logic signed [15:0] angular_cmd;
		logic [2:0]         stop_cause;
	} res_t;

	function automatic logic [2:0] mode_code(input mode_t m);
		logic [2:0] c;
		unique case (m)
			MODE_IDLE:   c = MODE_CODE_IDLE;
			MODE_LOCK:   c = MODE_CODE_LOCK;
			MODE_FUSED:  c = MODE_CODE_FUSED;
			MODE_HOLD:   c = MODE_CODE_HOLD;
			MODE_SEARCH: c = MODE_CODE_SEARCH;
			MODE_STOP:   c = MODE_CODE_STOP;
			default:     c = MODE_CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

FILE: src/tfm_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for observation and result words.
interface tfm_in_if;
	logic               valid;
	logic               ready;
	logic               target_seen;
	logic               cam_calib_ok;
	logic               scan_stale;
	logic               lidar_match;
	logic [9:0]         lidar_points;
	logic [15:0]        lidar_distance_mm;
	logic signed [12:0] bearing_mrad;
	logic [31:0]        visual_time_ms;
	logic [31:0]        now_ms;

	modport source (
		output valid, target_seen, cam_calib_ok, scan_stale, lidar_match,
		output lidar_points, lidar_distance_mm, bearing_mrad, visual_time_ms, now_ms,
		input  ready
	);
	modport sink (
		input  valid, target_seen, cam_calib_ok, scan_stale, lidar_match,
		input  lidar_points, lidar_distance_mm, bearing_mrad, visual_time_ms, now_ms,
		output ready
	);
endinterface

interface tfm_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [15:0] linear_cmd;
	logic signed [15:0] angular_cmd;
	logic [2:0]         stop_cause;

	modport source (
		output valid, mode, linear_cmd, angular_cmd, stop_cause,
		input  ready
	);
	modport sink (
		input  valid, mode, linear_cmd, angular_cmd, stop_cause,
		output ready
	);
endinterface

FILE: src/tfm_scale.sv
`timescale 1ns / 1ps
// Q8.8 gain multiply, truncate toward zero, symmetric clamp.
module tfm_scale (
	input  logic               en,
	input  logic [15:0]        gain,
	input  logic signed [16:0] value,
	input  logic [14:0]        limit,
	output logic signed [15:0] cmd
);
	import tfm_pkg::*;

	logic signed [33:0] prod;
	logic signed [33:0] bias;
	logic signed [33:0] prod_adj;
	logic signed [25:0] quo;
	logic signed [25:0] lim_pos;
	logic signed [25:0] lim_neg;
	logic signed [25:0] clamped;

	assign prod     = $signed({1'b0, gain}) * value;
	// negative products get 255 added so the shift rounds toward zero
	assign bias     = prod[33] ? 34'sd255 : 34'sd0;
	assign prod_adj = prod + bias;
	assign quo      = prod_adj[33:8];
	assign lim_pos  = $signed({11'd0, limit});
	assign lim_neg  = -lim_pos;

	always_comb begin
		if (quo > lim_pos) begin
			clamped = lim_pos;
		end else if (quo < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = quo;
		end
	end

	assign cmd = en ? clamped[15:0] : 16'sd0;

endmodule

FILE: src/tfm_fsm.sv
`timescale 1ns / 1ps
// Stop checks, follow mode state machine and tracked target state.
module tfm_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           update,
	input  tfm_pkg::item_t item,
	input  tfm_pkg::cfg_t  cfg,
	output logic [2:0]     mode,
	output tfm_pkg::cause_t cause,
	output tfm_pkg::drive_t drive
);
	import tfm_pkg::*;

	mode_t              mode_q, mode_n;
	logic [31:0]        last_vis_q, last_vis_n;
	logic [15:0]        held_dist_q, held_dist_n;
	logic signed [12:0] held_brg_q, held_brg_n;
	logic               held_valid_q, held_valid_n;
	logic signed [12:0] prior_brg_q, prior_brg_n;
	logic               prior_valid_q, prior_valid_n;

	logic               vis, fused_ok, jump_check, jump, vis_lost, hold_over;
	logic signed [13:0] brg_diff;
	logic [13:0]        brg_abs;
	cause_t             cause_pre;
	logic [15:0]        op_dist;
	logic signed [12:0] op_brg;

	assign vis      = item.target_seen;
	assign fused_ok = item.lidar_match && (item.lidar_points != 10'd0);

	always_comb begin
		if (!item.cam_calib_ok) begin
			cause_pre = CAUSE_CAMERA;
		end else if (item.scan_stale) begin
			cause_pre = CAUSE_SCAN;
		end else if (vis && item.lidar_match && item.lidar_distance_mm != 16'd0 &&
				item.lidar_distance_mm < cfg.min_safe_distance_mm) begin
			cause_pre = CAUSE_CLOSE;
		end else begin
			cause_pre = CAUSE_NONE;
		end
	end

	assign jump_check = (cause_pre == CAUSE_NONE) && vis;
	assign brg_diff   = 14'(item.bearing_mrad) - 14'(prior_brg_q);
	assign brg_abs    = brg_diff[13] ? 14'(-brg_diff) : 14'(brg_diff);
	assign jump       = jump_check && prior_valid_q && (brg_abs > {1'b0, cfg.max_jump_mrad});

	// visual timeout only matters in the two vision modes
	assign vis_lost = (last_vis_q != 32'd0) &&
		({1'b0, item.now_ms} > ({1'b0, last_vis_q} + 33'(VisualTimeoutMs))) &&
		((mode_q == MODE_LOCK) || (mode_q == MODE_FUSED));
	assign hold_over = {1'b0, item.now_ms} > ({1'b0, last_vis_q} + {17'd0, cfg.hold_timeout_ms});

	always_comb begin
		if (cause_pre != CAUSE_NONE) begin
			cause = cause_pre;
		end else if (jump) begin
			cause = CAUSE_JUMP;
		end else if (vis_lost) begin
			cause = CAUSE_VIS_LOST;
		end else begin
			cause = CAUSE_NONE;
		end
	end

	always_comb begin
		mode_n        = mode_q;
		last_vis_n    = last_vis_q;
		held_dist_n   = held_dist_q;
		held_brg_n    = held_brg_q;
		held_valid_n  = held_valid_q;
		prior_brg_n   = jump_check ? item.bearing_mrad : prior_brg_q;
		prior_valid_n = jump_check ? 1'b1 : prior_valid_q;
		drive.en      = 1'b0;
		op_dist       = item.lidar_distance_mm;
		op_brg        = item.bearing_mrad;
		if (cause != CAUSE_NONE) begin
			mode_n = MODE_STOP;
		end else begin
			if (vis) begin
				last_vis_n = item.visual_time_ms;
			end
			if (item.lidar_match) begin
				held_dist_n  = item.lidar_distance_mm;
				held_brg_n   = item.bearing_mrad;
				held_valid_n = 1'b1;
			end
			unique case (mode_q) inside
				MODE_IDLE, MODE_SEARCH: begin
					if (vis) begin
						mode_n = MODE_LOCK;
					end
				end
				MODE_LOCK: begin
					if (!vis) begin
						mode_n = MODE_SEARCH;
					end else if (fused_ok) begin
						mode_n   = MODE_FUSED;
						drive.en = 1'b1;
					end
				end
				MODE_FUSED: begin
					if (!vis) begin
						mode_n = MODE_HOLD;
					end else if (!fused_ok) begin
						mode_n = MODE_LOCK;
					end else begin
						drive.en = 1'b1;
					end
				end
				MODE_HOLD: begin
					op_dist = held_dist_n;
					op_brg  = held_brg_n;
					if (vis) begin
						mode_n = fused_ok ? MODE_FUSED : MODE_LOCK;
					end else if (hold_over) begin
						mode_n = MODE_SEARCH;
					end else if (held_valid_n) begin
						drive.en = 1'b1;
					end
				end
				MODE_STOP: begin
					// no stop check fired, so camera and scan are both fine
					mode_n        = MODE_IDLE;
					prior_valid_n = 1'b0;
					held_valid_n  = 1'b0;
				end
				default: begin
					mode_n = MODE_IDLE;
				end
			endcase
		end
		drive.lin_err = $signed({1'b0, op_dist}) - $signed({1'b0, cfg.desired_distance_mm});
		drive.ang_err = -17'(op_brg);
	end

	assign mode = mode_code(mode_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			last_vis_q    <= '0;
			held_dist_q   <= '0;
			held_brg_q    <= '0;
			held_valid_q  <= 1'b0;
			prior_brg_q   <= '0;
			prior_valid_q <= 1'b0;
		end else if (update) begin
			mode_q        <= mode_n;
			last_vis_q    <= last_vis_n;
			held_dist_q   <= held_dist_n;
			held_brg_q    <= held_brg_n;
			held_valid_q  <= held_valid_n;
			prior_brg_q   <= prior_brg_n;
			prior_valid_q <= prior_valid_n;
		end
	end

endmodule

FILE: src/target_follow_mode_fsm_core.sv
`timescale 1ns / 1ps
// Top level of the target follow mode controller.
//
//  channel   dir  handshake          word
//  in_ch     in   valid/ready        one fused camera/lidar observation
//  out_ch    out  valid/ready        mode, linear/angular command, stop cause
//  cfg_*     in   cfg_we only        register index 0..7, 16-bit data
//
// An accepted input word is held in the input register, which feeds the stop
// checks, mode update and one gain multiply per command; these load the result
// register. One word per cycle sustained while the result side is ready; the
// tracked state updates as a word moves into the result register. A stalled
// result holds, and the input register keeps accepting until it too is full.
// Reset loads register defaults and clears mode and tracking state.
module target_follow_mode_fsm_core (
	input  logic        clk,
	input  logic        arst_n,
	tfm_in_if.sink      in_ch,
	tfm_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tfm_pkg::*;

	cfg_t   cfg_q;
	item_t  item_s1;
	logic   valid_s1;
	res_t   res_q;
	logic   out_valid_q;
	logic   advance;
	logic   in_take;
	logic [2:0] mode_nx;
	cause_t cause_nx;
	drive_t drive;
	logic signed [15:0] lin_cmd, ang_cmd;

	assign advance      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign in_take      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.desired_distance_mm  <= 16'd1000;
			cfg_q.min_safe_distance_mm <= 16'd300;
			cfg_q.linear_gain          <= 16'd128;
			cfg_q.angular_gain         <= 16'd128;
			cfg_q.linear_limit         <= 15'd500;
			cfg_q.angular_limit        <= 15'd500;
			cfg_q.hold_timeout_ms      <= 16'd1000;
			cfg_q.max_jump_mrad        <= 13'd524;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DESIRED_DIST: cfg_q.desired_distance_mm  <= cfg_data;
				REG_MIN_SAFE:     cfg_q.min_safe_distance_mm <= cfg_data;
				REG_LIN_GAIN:     cfg_q.linear_gain          <= cfg_data;
				REG_ANG_GAIN:     cfg_q.angular_gain         <= cfg_data;
				REG_LIN_LIMIT:    cfg_q.linear_limit         <= cfg_data[14:0];
				REG_ANG_LIMIT:    cfg_q.angular_limit        <= cfg_data[14:0];
				REG_HOLD_TIMEOUT: cfg_q.hold_timeout_ms      <= cfg_data;
				REG_MAX_JUMP:     cfg_q.max_jump_mrad        <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.target_seen       <= in_ch.target_seen;
			item_s1.cam_calib_ok      <= in_ch.cam_calib_ok;
			item_s1.scan_stale        <= in_ch.scan_stale;
			item_s1.lidar_match       <= in_ch.lidar_match;
			item_s1.lidar_points      <= in_ch.lidar_points;
			item_s1.lidar_distance_mm <= in_ch.lidar_distance_mm;
			item_s1.bearing_mrad      <= in_ch.bearing_mrad;
			item_s1.visual_time_ms    <= in_ch.visual_time_ms;
			item_s1.now_ms            <= in_ch.now_ms;
		end
	end

	tfm_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.mode   (mode_nx),
		.cause  (cause_nx),
		.drive  (drive)
	);

	tfm_scale u_lin (
		.en    (drive.en),
		.gain  (cfg_q.linear_gain),
		.value (drive.lin_err),
		.limit (cfg_q.linear_limit),
		.cmd   (lin_cmd)
	);

	tfm_scale u_ang (
		.en    (drive.en),
		.gain  (cfg_q.angular_gain),
		.value (drive.ang_err),
		.limit (cfg_q.angular_limit),
		.cmd   (ang_cmd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.mode        <= mode_nx;
			res_q.linear_cmd  <= lin_cmd;
			res_q.angular_cmd <= ang_cmd;
			res_q.stop_cause  <= cause_nx;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.mode        = res_q.mode;
	assign out_ch.linear_cmd  = res_q.linear_cmd;
	assign out_ch.angular_cmd = res_q.angular_cmd;
	assign out_ch.stop_cause  = res_q.stop_cause;

	// a word reports stop mode exactly when a stop check fired
	a_stop_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((res_q.stop_cause != CAUSE_NONE) == (res_q.mode == MODE_CODE_STOP)))
		else $error("stop cause and stop mode disagree");

	// a stopped word carries no motion
	a_stop_still: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.stop_cause != CAUSE_NONE) |->
			(res_q.linear_cmd == 16'sd0 && res_q.angular_cmd == 16'sd0))
		else $error("motion command on a stop word");

	// a word held back in the input register is neither dropped nor altered
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost a stalled word");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Follow mode controller testbench: directed and random observations against a behavioral predictor.
module tb_top;
	import tfm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 140;
	localparam int HOLD_OFF_CYCLES = 60;

	localparam cfg_t CFG_RESET = '{16'd1000, 16'd300, 16'd128, 16'd128,
		15'd500, 15'd500, 16'd1000, 13'd524};
	localparam cfg_t CFG_MAX = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		15'h7FFF, 15'h7FFF, 16'hFFFF, 13'd6283};

	typedef struct {
		item_t w;
		bit    typed;
		res_t  want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	tfm_in_if in_ch();
	tfm_out_if out_ch();

	always #10 clk = ~clk;

	target_follow_mode_fsm_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of registers and tracking state
	cfg_t cfg;
	logic [2:0] fmode;
	logic [31:0] last_vis_ms;
	logic [15:0] held_dist;
	int held_brg;
	bit held_ok;
	int prior_brg;
	bit prior_ok;

	res_t cmd_q[$];
	row_t plan[$];
	int fails = 0;
	int cycles = 0;
	bit steady = 1'b0;
	bit hold_off_req = 1'b0;
	int unsigned wt = 0;
	int wb = 0;

	function automatic bit past_limit(logic [31:0] nw, logic [31:0] since, logic [31:0] lim);
		return {32'b0, nw} > {32'b0, since} + {32'b0, lim};
	endfunction

	function automatic longint scale_cmd(longint gain, longint err, longint limit);
		longint p;
		p = gain * err / 256;
		if (p > limit)
			p = limit;
		if (p < -limit)
			p = -limit;
		return p;
	endfunction

	function automatic res_t follow_predict(item_t w);
		res_t r;
		cause_t c;
		longint lin;
		longint ang;
		int diff;
		bit fused_ok;
		lin = 0;
		ang = 0;
		c = CAUSE_NONE;
		fused_ok = w.lidar_match && (w.lidar_points != 0);

		if (!w.cam_calib_ok) begin
			c = CAUSE_CAMERA;
		end else if (w.scan_stale) begin
			c = CAUSE_SCAN;
		end else if (w.target_seen && w.lidar_match && w.lidar_distance_mm != 0 &&
				w.lidar_distance_mm < cfg.min_safe_distance_mm) begin
			c = CAUSE_CLOSE;
		end
		// prior bearing moves on every valid frame that gets here, even when the jump fires
		if (c == CAUSE_NONE && w.target_seen) begin
			if (!prior_ok) begin
				prior_ok = 1'b1;
			end else begin
				diff = int'(w.bearing_mrad) - prior_brg;
				if (diff < 0)
					diff = -diff;
				if (diff > int'(cfg.max_jump_mrad))
					c = CAUSE_JUMP;
			end
			prior_brg = int'(w.bearing_mrad);
		end
		if (c == CAUSE_NONE && last_vis_ms != 0 &&
				past_limit(w.now_ms, last_vis_ms, 32'(VisualTimeoutMs)) &&
				(fmode == MODE_CODE_LOCK || fmode == MODE_CODE_FUSED))
			c = CAUSE_VIS_LOST;

		if (c != CAUSE_NONE) begin
			fmode = MODE_CODE_STOP;
		end else begin
			if (w.target_seen)
				last_vis_ms = w.visual_time_ms;
			if (w.lidar_match) begin
				held_dist = w.lidar_distance_mm;
				held_brg = int'(w.bearing_mrad);
				held_ok = 1'b1;
			end
			case (fmode) inside
				MODE_CODE_IDLE, MODE_CODE_SEARCH: begin
					if (w.target_seen && w.cam_calib_ok)
						fmode = MODE_CODE_LOCK;
				end
				MODE_CODE_LOCK, MODE_CODE_FUSED: begin
					if (!w.target_seen) begin
						fmode = (fmode == MODE_CODE_LOCK) ? MODE_CODE_SEARCH : MODE_CODE_HOLD;
					end else if (!fused_ok) begin
						fmode = MODE_CODE_LOCK;
					end else begin
						fmode = MODE_CODE_FUSED;
						lin = scale_cmd(longint'(cfg.linear_gain),
							longint'(w.lidar_distance_mm) - longint'(cfg.desired_distance_mm),
							longint'(cfg.linear_limit));
						ang = scale_cmd(longint'(cfg.angular_gain), -longint'(w.bearing_mrad),
							longint'(cfg.angular_limit));
					end
				end
				MODE_CODE_HOLD: begin
					if (w.target_seen) begin
						fmode = fused_ok ? MODE_CODE_FUSED : MODE_CODE_LOCK;
					end else if (past_limit(w.now_ms, last_vis_ms, {16'b0, cfg.hold_timeout_ms})) begin
						fmode = MODE_CODE_SEARCH;
					end else if (held_ok) begin
						lin = scale_cmd(longint'(cfg.linear_gain),
							longint'(held_dist) - longint'(cfg.desired_distance_mm),
							longint'(cfg.linear_limit));
						ang = scale_cmd(longint'(cfg.angular_gain), -longint'(held_brg),
							longint'(cfg.angular_limit));
					end
				end
				default: begin
					if (w.cam_calib_ok && !w.scan_stale) begin
						fmode = MODE_CODE_IDLE;
						prior_ok = 1'b0;
						held_ok = 1'b0;
					end
				end
			endcase
		end

		r.mode = fmode;
		r.linear_cmd = lin[15:0];
		r.angular_cmd = ang[15:0];
		r.stop_cause = c;
		return r;
	endfunction

	function automatic row_t row(bit vis, bit cam, bit scan, bit assoc, int pts, int dist_mm,
			int brg, logic [31:0] vt, logic [31:0] nw, bit typed, logic [2:0] md, cause_t cs);
		row_t e;
		e.w.target_seen = vis;
		e.w.cam_calib_ok = cam;
		e.w.scan_stale = scan;
		e.w.lidar_match = assoc;
		e.w.lidar_points = 10'(pts);
		e.w.lidar_distance_mm = 16'(dist_mm);
		e.w.bearing_mrad = 13'(brg);
		e.w.visual_time_ms = vt;
		e.w.now_ms = nw;
		e.typed = typed;
		e.want.mode = md;
		e.want.linear_cmd = '0;
		e.want.angular_cmd = '0;
		e.want.stop_cause = cs;
		return e;
	endfunction

	// mostly a coherent track: time moves forward, bearing drifts; some pure noise
	function automatic item_t rand_obs();
		item_t w;
		int d;
		int pick;
		if ($urandom_range(99) < 5) begin
			w.target_seen = 1'($urandom_range(1));
			w.cam_calib_ok = 1'($urandom_range(1));
			w.scan_stale = 1'($urandom_range(1));
			w.lidar_match = 1'($urandom_range(1));
			w.lidar_points = 10'($urandom_range(1023));
			w.lidar_distance_mm = 16'($urandom_range(65535));
			w.bearing_mrad = 13'(int'($urandom_range(6284)) - 3142);
			w.visual_time_ms = $urandom;
			w.now_ms = $urandom;
			return w;
		end
		wt += ($urandom_range(99) < 4) ? $urandom_range(3000, 500) : $urandom_range(250);
		wb += int'($urandom_range(400)) - 200;
		if ($urandom_range(99) < 5)
			wb = int'($urandom_range(6284)) - 3142;
		if (wb > 3142)
			wb = 3142;
		if (wb < -3142)
			wb = -3142;
		w.target_seen = $urandom_range(99) < 75;
		w.cam_calib_ok = $urandom_range(99) >= 3;
		w.scan_stale = $urandom_range(99) < 3;
		w.lidar_match = $urandom_range(99) < 70;
		w.lidar_points = ($urandom_range(99) < 15) ? 10'd0 : 10'($urandom_range(1023, 1));
		pick = $urandom_range(99);
		if (pick < 70) begin
			d = int'(cfg.desired_distance_mm) + int'($urandom_range(4000)) - 2000;
			if (d < 0)
				d = 0;
			if (d > 65535)
				d = 65535;
		end else if (pick < 80) begin
			d = $urandom_range(400);
		end else begin
			d = $urandom_range(65535);
		end
		w.lidar_distance_mm = 16'(d);
		w.bearing_mrad = 13'(wb);
		pick = $urandom_range(99);
		w.visual_time_ms = (pick < 90) ? wt : ((pick < 95) ? 32'd0 : $urandom);
		w.now_ms = wt;
		return w;
	endfunction

	function automatic cfg_t pick_cfg(bit tame);
		cfg_t c;
		if (tame) begin
			c.desired_distance_mm = 16'($urandom_range(3000, 500));
			c.min_safe_distance_mm = 16'($urandom_range(600, 100));
			c.linear_gain = 16'($urandom_range(1024, 16));
			c.angular_gain = 16'($urandom_range(1024, 16));
			c.linear_limit = 15'($urandom_range(32767, 100));
			c.angular_limit = 15'($urandom_range(32767, 100));
			c.hold_timeout_ms = 16'($urandom_range(3000, 200));
			c.max_jump_mrad = 13'($urandom_range(2000, 200));
		end else begin
			c.desired_distance_mm = 16'($urandom_range(65535));
			c.min_safe_distance_mm = 16'($urandom_range(65535));
			c.linear_gain = 16'($urandom_range(65535));
			c.angular_gain = 16'($urandom_range(65535));
			c.linear_limit = 15'($urandom_range(32767));
			c.angular_limit = 15'($urandom_range(32767));
			c.hold_timeout_ms = 16'($urandom_range(65535));
			c.max_jump_mrad = 13'($urandom_range(6283));
		end
		return c;
	endfunction

	task automatic send_obs(item_t w, bit typed, res_t want);
		res_t guess;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 18) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.target_seen <= w.target_seen;
		in_ch.cam_calib_ok <= w.cam_calib_ok;
		in_ch.scan_stale <= w.scan_stale;
		in_ch.lidar_match <= w.lidar_match;
		in_ch.lidar_points <= w.lidar_points;
		in_ch.lidar_distance_mm <= w.lidar_distance_mm;
		in_ch.bearing_mrad <= w.bearing_mrad;
		in_ch.visual_time_ms <= w.visual_time_ms;
		in_ch.now_ms <= w.now_ms;
		do @(posedge clk); while (!in_ch.ready);
		guess = follow_predict(w);
		cmd_q.push_back(typed ? want : guess);
	endtask

	// stop offering and let every outstanding word come back
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (cmd_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_DESIRED_DIST: cfg.desired_distance_mm = val;
			REG_MIN_SAFE:     cfg.min_safe_distance_mm = val;
			REG_LIN_GAIN:     cfg.linear_gain = val;
			REG_ANG_GAIN:     cfg.angular_gain = val;
			REG_LIN_LIMIT:    cfg.linear_limit = val[14:0];
			REG_ANG_LIMIT:    cfg.angular_limit = val[14:0];
			REG_HOLD_TIMEOUT: cfg.hold_timeout_ms = val;
			REG_MAX_JUMP:     cfg.max_jump_mrad = val[12:0];
			default: ;
		endcase
	endtask

	task automatic set_cfg(cfg_t c);
		write_reg(REG_DESIRED_DIST, c.desired_distance_mm);
		write_reg(REG_MIN_SAFE, c.min_safe_distance_mm);
		write_reg(REG_LIN_GAIN, c.linear_gain);
		write_reg(REG_ANG_GAIN, c.angular_gain);
		write_reg(REG_LIN_LIMIT, {1'b0, c.linear_limit});
		write_reg(REG_ANG_LIMIT, {1'b0, c.angular_limit});
		write_reg(REG_HOLD_TIMEOUT, c.hold_timeout_ms);
		write_reg(REG_MAX_JUMP, {3'b0, c.max_jump_mrad});
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end else begin
				out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= 18);
			end
		end
	end

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cmd_q.size() == 0) begin
				$error("result word with nothing expected: mode %0d", out_ch.mode);
				fails++;
			end else begin
				want = cmd_q.pop_front();
				if (out_ch.mode !== want.mode) begin
					$error("mode: expected %0d, got %0d", want.mode, out_ch.mode);
					fails++;
				end
				if (out_ch.linear_cmd !== want.linear_cmd) begin
					$error("linear_cmd: expected %0d, got %0d", want.linear_cmd, out_ch.linear_cmd);
					fails++;
				end
				if (out_ch.angular_cmd !== want.angular_cmd) begin
					$error("angular_cmd: expected %0d, got %0d", want.angular_cmd,
						out_ch.angular_cmd);
					fails++;
				end
				if (out_ch.stop_cause !== want.stop_cause) begin
					$error("stop_cause: expected %0d, got %0d", want.stop_cause,
						out_ch.stop_cause);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		in_ch.valid = 1'b0;
		in_ch.target_seen = 1'b0;
		in_ch.cam_calib_ok = 1'b0;
		in_ch.scan_stale = 1'b0;
		in_ch.lidar_match = 1'b0;
		in_ch.lidar_points = '0;
		in_ch.lidar_distance_mm = '0;
		in_ch.bearing_mrad = '0;
		in_ch.visual_time_ms = '0;
		in_ch.now_ms = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;

		cfg = CFG_RESET;
		fmode = MODE_CODE_IDLE;
		last_vis_ms = '0;
		held_dist = '0;
		held_brg = 0;
		held_ok = 1'b0;
		prior_brg = 0;
		prior_ok = 1'b0;

		// vis cam scan assoc pts dist brg vtime now | typed mode cause
		plan.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, MODE_CODE_STOP, CAUSE_CAMERA));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 0, 1, MODE_CODE_IDLE, CAUSE_NONE));
		plan.push_back(row(0, 1, 1, 0, 0, 0, 0, 0, 0, 1, MODE_CODE_STOP, CAUSE_SCAN));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 0, 1, MODE_CODE_IDLE, CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 0, 0, 0, 100, 1000, 1000, 1, MODE_CODE_LOCK, CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 1, 5, 3000, 100, 1100, 1100, 0, MODE_CODE_IDLE, CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 1, 1023, 65535, 600, 1200, 1200, 0, MODE_CODE_IDLE,
			CAUSE_NONE));
		// target inside the safety distance
		plan.push_back(row(1, 1, 0, 1, 1, 100, 600, 1250, 1250, 1, MODE_CODE_STOP, CAUSE_CLOSE));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 1300, 1, MODE_CODE_IDLE, CAUSE_NONE));
		// bearing swings from one extreme to the other
		plan.push_back(row(1, 1, 0, 0, 0, 0, 3142, 2000, 2000, 1, MODE_CODE_LOCK, CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 0, 0, 0, -3142, 2010, 2010, 1, MODE_CODE_STOP, CAUSE_JUMP));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 2020, 1, MODE_CODE_IDLE, CAUSE_NONE));
		// vision lost for too long while locked
		plan.push_back(row(1, 1, 0, 0, 0, 0, 0, 5000, 5000, 1, MODE_CODE_LOCK, CAUSE_NONE));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 6000, 1, MODE_CODE_STOP, CAUSE_VIS_LOST));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 6001, 1, MODE_CODE_IDLE, CAUSE_NONE));
		// zero visual time reads as never seen, so no timeout afterwards
		plan.push_back(row(1, 1, 0, 0, 0, 0, 0, 0, 10, 1, MODE_CODE_LOCK, CAUSE_NONE));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1, MODE_CODE_SEARCH,
			CAUSE_NONE));
		// zero distance is not too close
		plan.push_back(row(1, 1, 0, 1, 1023, 0, -500, 20000, 20000, 1, MODE_CODE_LOCK,
			CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 1, 1, 1000, -500, 20050, 20050, 0, MODE_CODE_IDLE,
			CAUSE_NONE));
		plan.push_back(row(0, 1, 0, 1, 3, 2000, -1000, 0, 20100, 0, MODE_CODE_IDLE, CAUSE_NONE));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 20200, 0, MODE_CODE_IDLE, CAUSE_NONE));
		plan.push_back(row(0, 1, 0, 0, 0, 0, 0, 0, 21051, 1, MODE_CODE_SEARCH, CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 1, 0, 5000, -500, 21100, 21100, 1, MODE_CODE_LOCK,
			CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 1, 0, 5000, -400, 21150, 21150, 1, MODE_CODE_LOCK,
			CAUSE_NONE));
		// clock behind the last visual time
		plan.push_back(row(1, 1, 0, 1, 7, 400, -400, 21200, 21100, 0, MODE_CODE_IDLE,
			CAUSE_NONE));
		plan.push_back(row(1, 1, 0, 0, 7, 400, -400, 21300, 21300, 1, MODE_CODE_LOCK,
			CAUSE_NONE));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[k])
			send_obs(plan[k].w, plan[k].typed, plan[k].want);

		for (int p = 0; p < 6; p++) begin
			case (p) inside
				0, 4: c = pick_cfg(1'b1);
				1: c = CFG_MAX;
				2: c = '0;
				3: c = pick_cfg(1'b0);
				default: c = CFG_RESET;
			endcase
			drain();
			set_cfg(c);
			steady = (p == 4);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (p == 0 && i == 40)
					hold_off_req = 1'b1;
				if (p == 3 && i == 70)
					drain();
				send_obs(rand_obs(), 1'b0, '0);
			end
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: files.f
src/tfm_pkg.sv
src/tfm_ifs.sv
src/tfm_scale.sv
src/tfm_fsm.sv
src/target_follow_mode_fsm_core.sv
verif/tb_top.sv
